FILE: rtl/line_follow_pid_drive_core_defines.svh
// Assertion macros shared by the line follower drive core.
// Depends on nothing; taken in by the top level with `include.
`ifndef LINE_FOLLOW_PID_DRIVE_CORE_DEFINES_SVH
`define LINE_FOLLOW_PID_DRIVE_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define LFPD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lfpd: same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset
`define LFPD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lfpd: next-cycle check failed");

`endif

FILE: rtl/lfpd_pkg.sv
// Shared constants, types and the sensor weight table of the line follower drive.
// Used by lfpd_ctrl, lfpd_datapath and line_follow_pid_drive_core.
package lfpd_pkg;

    // Sensor front end
    localparam int SENSOR_COUNT = 7;
    localparam int SENSOR_BITS  = 7;
    localparam int WEIGHT_W     = 4;
    localparam int WSUM_W       = 5;
    localparam int CNT_W        = 3;
    localparam int FRAC_BITS    = 8;

    // Divider: two quotient bits per step
    localparam int DIVIDEND_W   = WSUM_W - 1 + FRAC_BITS;
    localparam int DIV_STEPS    = DIVIDEND_W / 2;
    localparam int DIV_STEP_W   = $clog2(DIV_STEPS);

    // Control law widths
    localparam int GAIN_W       = 16;
    localparam int SPEED_W      = 8;
    localparam int ERR_W        = 12;
    localparam int OUT_ERR_W    = 11;
    localparam int DIFF_W       = ERR_W + 1;
    localparam int SUM_W        = 24;
    localparam int PROD_W       = GAIN_W + SUM_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int SHIFT        = 16;
    localparam int CORR_W       = ACC_W - SHIFT;
    localparam int DRV_W        = CORR_W + 2;

    // Configuration port
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_P     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_I     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_D     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_SPEED = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOP_SPEED  = 3'd4;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST     = 16'sd5120;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST     = 16'sd5;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST     = 16'sd1280;
    localparam logic [SPEED_W-1:0]       BASE_SPEED_RST = 8'd150;
    localparam logic [SPEED_W-1:0]       TOP_SPEED_RST  = 8'd255;

    // Sensor weights, left to right; sensors past the table weigh +4
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_TABLE [8] = '{
        -4'sd4, -4'sd3, -4'sd2, -4'sd1, 4'sd1, 4'sd2, 4'sd3, 4'sd4
    };

    function automatic logic signed [WEIGHT_W-1:0] sensor_weight(input int idx);
        logic signed [WEIGHT_W-1:0] w;
        if (idx < 8)
            w = WEIGHT_TABLE[idx[2:0]];
        else
            w = 4'sd4;
        return w;
    endfunction

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_FINISH
    } state_t;

    // Multiplier operand pair
    typedef enum logic [1:0] {
        MUL_GAIN_P,
        MUL_GAIN_I,
        MUL_GAIN_D
    } mul_sel_t;

    // Accumulator action
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     err_load;
        logic     mul_en;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic seen;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/line_follow_pid_drive_core.sv
// Top level of the line follower PID wheel drive.
// Depends on lfpd_pkg, lfpd_ctrl, lfpd_datapath and the assertion macro header.

// One sample of line-sensor bits in, one result out: left and right wheel
// drive levels, the Q8 centroid error and a line-seen flag. A sample is
// taken only while the core is idle; it then passes through the
// two-bit-per-step divider that forms the centroid (cut short when no
// sensor sees the line), an error-settle state, the single shared 16x24
// multiplier and its accumulator for the three PID products, and a finish
// state. The next sample is taken only once this result is handed to the
// output register, so a finished result waiting on a stalled output
// register holds off new samples. The user must write gains and speeds through
// the cfg port only while no sample is in flight; the block does not enforce it.
`include "line_follow_pid_drive_core_defines.svh"

module line_follow_pid_drive_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_write,
    input  logic [lfpd_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // sensor sample channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [lfpd_pkg::SENSOR_BITS-1:0]       sensor_bits,
    // drive result channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [lfpd_pkg::SPEED_W-1:0]           left_speed,
    output logic [lfpd_pkg::SPEED_W-1:0]           right_speed,
    output logic signed [lfpd_pkg::OUT_ERR_W-1:0]  line_error,
    output logic                                   line_seen
);

    lfpd_pkg::cmd_t    cmd;
    lfpd_pkg::status_t status;

    lfpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    lfpd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .sensor_bits (sensor_bits),
        .cfg_write   (cfg_write),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .line_error  (line_error),
        .line_seen   (line_seen)
    );

    // a taken sample makes the core busy
    `LFPD_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && !in_stall, in_stall)
    // a result never overwrites one still held by a stalled sink
    `LFPD_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.finish, !out_valid || !out_stall)
    // a finished result shows up on the output
    `LFPD_ASSERT_NEXT(a_finish_shows, clk, rst_n, cmd.finish, out_valid)
    // a delivered beat is not repeated
    `LFPD_ASSERT_NEXT(a_no_repeat, clk, rst_n, out_valid && !out_stall && !cmd.finish, !out_valid)

endmodule

FILE: rtl/lfpd_ctrl.sv
// Sequencer of the line follower drive: accept, divide, multiply-accumulate, finish.
// Depends on lfpd_pkg; drives the datapath through lfpd_pkg::cmd_t.
module lfpd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  lfpd_pkg::status_t status,
    output lfpd_pkg::cmd_t    cmd,
    output logic              in_stall
);

    localparam logic [lfpd_pkg::DIV_STEP_W-1:0] DIV_LAST =
        lfpd_pkg::DIV_STEP_W'(lfpd_pkg::DIV_STEPS - 1);

    lfpd_pkg::state_t state_reg, state_next;
    logic [lfpd_pkg::DIV_STEP_W-1:0] div_cnt_reg, div_cnt_next;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lfpd_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = '0;
        case (state_reg)
            lfpd_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = lfpd_pkg::ST_DIV;
            end
            lfpd_pkg::ST_DIV:
            begin
                // no line seen: the held error needs no quotient
                if (!status.seen || div_cnt_reg == DIV_LAST)
                    state_next = lfpd_pkg::ST_ERR;
                else
                    div_cnt_next = div_cnt_reg + 1'b1;
            end
            lfpd_pkg::ST_ERR:   state_next = lfpd_pkg::ST_MUL_P;
            lfpd_pkg::ST_MUL_P: state_next = lfpd_pkg::ST_MUL_I;
            lfpd_pkg::ST_MUL_I: state_next = lfpd_pkg::ST_MUL_D;
            lfpd_pkg::ST_MUL_D: state_next = lfpd_pkg::ST_ACC;
            lfpd_pkg::ST_ACC:   state_next = lfpd_pkg::ST_FINISH;
            lfpd_pkg::ST_FINISH:
            begin
                if (status.out_free)
                    state_next = lfpd_pkg::ST_IDLE;
            end
            default:            state_next = lfpd_pkg::ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = lfpd_pkg::MUL_GAIN_P;
        cmd.acc_op   = lfpd_pkg::ACC_HOLD;
        in_stall     = 1'b1;
        case (state_reg)
            lfpd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            lfpd_pkg::ST_DIV:   cmd.div_step = 1'b1;
            lfpd_pkg::ST_ERR:   cmd.err_load = 1'b1;
            lfpd_pkg::ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lfpd_pkg::MUL_GAIN_P;
            end
            lfpd_pkg::ST_MUL_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lfpd_pkg::MUL_GAIN_I;
                cmd.acc_op  = lfpd_pkg::ACC_LOAD;
            end
            lfpd_pkg::ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lfpd_pkg::MUL_GAIN_D;
                cmd.acc_op  = lfpd_pkg::ACC_ADD;
            end
            lfpd_pkg::ST_ACC:   cmd.acc_op = lfpd_pkg::ACC_ADD;
            lfpd_pkg::ST_FINISH: cmd.finish = status.out_free;
            default:            cmd = '0;
        endcase
    end

endmodule

FILE: rtl/lfpd_datapath.sv
// Datapath of the line follower drive: centroid, divider, shared multiplier,
// PID state, configuration registers and output register. Depends on lfpd_pkg.
module lfpd_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [lfpd_pkg::SENSOR_BITS-1:0]       sensor_bits,
    input  logic                                   cfg_write,
    input  logic [lfpd_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  lfpd_pkg::cmd_t                         cmd,
    output lfpd_pkg::status_t                      status,
    input  logic                                   out_stall,
    output logic                                   out_valid,
    output logic [lfpd_pkg::SPEED_W-1:0]           left_speed,
    output logic [lfpd_pkg::SPEED_W-1:0]           right_speed,
    output logic signed [lfpd_pkg::OUT_ERR_W-1:0]  line_error,
    output logic                                   line_seen
);

    localparam int SW  = lfpd_pkg::SPEED_W;
    localparam int DW  = lfpd_pkg::DIVIDEND_W;
    localparam int CW  = lfpd_pkg::CNT_W;
    localparam int EW  = lfpd_pkg::ERR_W;
    localparam int OEW = lfpd_pkg::OUT_ERR_W;
    localparam int SUW = lfpd_pkg::SUM_W;
    localparam int VW  = lfpd_pkg::DRV_W;

    // Configuration registers
    logic signed [lfpd_pkg::GAIN_W-1:0] gain_p_reg, gain_p_next;
    logic signed [lfpd_pkg::GAIN_W-1:0] gain_i_reg, gain_i_next;
    logic signed [lfpd_pkg::GAIN_W-1:0] gain_d_reg, gain_d_next;
    logic [SW-1:0]                      base_reg, base_next;
    logic [SW-1:0]                      top_reg, top_next;

    // PID state and output control
    logic signed [EW-1:0]  last_err_reg, last_err_next;
    logic signed [SUW-1:0] error_sum_reg, error_sum_next;
    logic                  out_valid_reg, out_valid_next;

    // Working registers
    logic                                  seen_reg, seen_next;
    logic                                  neg_reg, neg_next;
    logic [CW-1:0]                         cnt_reg, cnt_next;
    logic [DW-1:0]                         dvd_reg, dvd_next;
    logic [CW-1:0]                         rem_reg, rem_next;
    logic [DW-1:0]                         quo_reg, quo_next;
    logic signed [EW-1:0]                  err_reg, err_next;
    logic signed [lfpd_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic signed [lfpd_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [SW-1:0]                         left_reg, left_next;
    logic [SW-1:0]                         right_reg, right_next;
    logic signed [OEW-1:0]                 line_err_reg, line_err_next;
    logic                                  line_seen_reg, line_seen_next;

    // Combinational helpers
    logic signed [lfpd_pkg::WSUM_W-1:0]    wsum_now, mag_now;
    logic [CW-1:0]                         cnt_now;
    logic [CW:0]                           r1, r2;
    logic                                  q1, q2;
    logic signed [EW-1:0]                  quo_signed;
    logic signed [lfpd_pkg::DIFF_W-1:0]    diff;
    logic signed [lfpd_pkg::GAIN_W-1:0]    mul_a;
    logic signed [SUW-1:0]                 mul_b;
    logic signed [lfpd_pkg::CORR_W-1:0]    corr;
    logic signed [VW-1:0]                  base_ext, top_ext, lsum, rsum;
    logic signed [SUW:0]                   sum_ext;

    function automatic logic [SW-1:0] clamp_drive(input logic signed [VW-1:0] v,
                                                  input logic signed [VW-1:0] top);
        logic [SW-1:0] r;
        if (v < 0)
            r = '0;
        else if (v > top)
            r = top[SW-1:0];
        else
            r = v[SW-1:0];
        return r;
    endfunction

    // Weighted sum and count of the sensors that see the line
    always_comb
    begin
        wsum_now = '0;
        cnt_now  = '0;
        for (int i = 0; i < lfpd_pkg::SENSOR_BITS; i++)
        begin
            if (i < lfpd_pkg::SENSOR_COUNT && sensor_bits[i])
            begin
                wsum_now = wsum_now + lfpd_pkg::WSUM_W'(lfpd_pkg::sensor_weight(i));
                cnt_now  = cnt_now + 1'b1;
            end
        end
        mag_now = (wsum_now < 0) ? -wsum_now : wsum_now;
    end

    // Radix-4 restoring divide step on the magnitude
    always_comb
    begin
        q1 = 1'b0;
        q2 = 1'b0;
        r1 = {rem_reg, dvd_reg[DW-1]};
        if (r1 >= {1'b0, cnt_reg})
        begin
            q1 = 1'b1;
            r1 = r1 - {1'b0, cnt_reg};
        end
        r2 = {r1[CW-1:0], dvd_reg[DW-2]};
        if (r2 >= {1'b0, cnt_reg})
        begin
            q2 = 1'b1;
            r2 = r2 - {1'b0, cnt_reg};
        end
    end

    // Multiplier operands and error difference
    always_comb
    begin
        diff = lfpd_pkg::DIFF_W'(err_reg) - lfpd_pkg::DIFF_W'(last_err_reg);
        case (cmd.mul_sel)
            lfpd_pkg::MUL_GAIN_P:
            begin
                mul_a = gain_p_reg;
                mul_b = SUW'(err_reg);
            end
            lfpd_pkg::MUL_GAIN_I:
            begin
                mul_a = gain_i_reg;
                mul_b = error_sum_reg;
            end
            lfpd_pkg::MUL_GAIN_D:
            begin
                mul_a = gain_d_reg;
                mul_b = SUW'(diff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Correction and wheel drive sums; floor shift is a plain bit slice
    assign corr       = acc_reg[lfpd_pkg::ACC_W-1:lfpd_pkg::SHIFT];
    assign base_ext   = $signed({{(VW-SW){1'b0}}, base_reg});
    assign top_ext    = $signed({{(VW-SW){1'b0}}, top_reg});
    assign lsum       = base_ext + VW'(corr);
    assign rsum       = base_ext - VW'(corr);
    assign sum_ext    = (SUW+1)'(error_sum_reg) + (SUW+1)'(err_reg);
    assign quo_signed = $signed({1'b0, quo_reg[EW-2:0]});

    // Next values
    always_comb
    begin
        gain_p_next    = gain_p_reg;
        gain_i_next    = gain_i_reg;
        gain_d_next    = gain_d_reg;
        base_next      = base_reg;
        top_next       = top_reg;
        last_err_next  = last_err_reg;
        error_sum_next = error_sum_reg;
        out_valid_next = out_valid_reg;
        seen_next      = seen_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        err_next       = err_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        line_err_next  = line_err_reg;
        line_seen_next = line_seen_reg;

        // config writes; unknown indexes are dropped
        if (cfg_write)
        begin
            case (cfg_addr)
                lfpd_pkg::CFG_GAIN_P:     gain_p_next = $signed(cfg_wdata);
                lfpd_pkg::CFG_GAIN_I:     gain_i_next = $signed(cfg_wdata);
                lfpd_pkg::CFG_GAIN_D:     gain_d_next = $signed(cfg_wdata);
                lfpd_pkg::CFG_BASE_SPEED: base_next   = cfg_wdata[SW-1:0];
                lfpd_pkg::CFG_TOP_SPEED:  top_next    = cfg_wdata[SW-1:0];
                default:                  ;
            endcase
        end

        // input beat: latch centroid terms, prime the divider
        if (cmd.load)
        begin
            seen_next = (cnt_now != '0);
            neg_next  = (wsum_now < 0);
            cnt_next  = cnt_now;
            dvd_next  = {mag_now[lfpd_pkg::WSUM_W-2:0], {lfpd_pkg::FRAC_BITS{1'b0}}};
            rem_next  = '0;
            quo_next  = '0;
        end

        if (cmd.div_step)
        begin
            quo_next = {quo_reg[DW-3:0], q1, q2};
            dvd_next = {dvd_reg[DW-3:0], 2'b00};
            rem_next = r2[CW-1:0];
        end

        // error: signed quotient, or the held one when the line is lost
        if (cmd.err_load)
        begin
            if (seen_reg)
                err_next = neg_reg ? -quo_signed : quo_signed;
            else
                err_next = last_err_reg;
        end

        if (cmd.mul_en)
            prod_next = mul_a * mul_b;

        case (cmd.acc_op)
            lfpd_pkg::ACC_LOAD: acc_next = lfpd_pkg::ACC_W'(prod_reg);
            lfpd_pkg::ACC_ADD:  acc_next = acc_reg + lfpd_pkg::ACC_W'(prod_reg);
            default:            acc_next = acc_reg;
        endcase

        // output beat taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        // result: drive levels, state update, output register load
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            left_next      = clamp_drive(lsum, top_ext);
            right_next     = clamp_drive(rsum, top_ext);
            line_seen_next = seen_reg;
            if (err_reg[EW-1] != err_reg[EW-2])
                line_err_next = err_reg[EW-1] ? {1'b1, {(OEW-1){1'b0}}}
                                              : {1'b0, {(OEW-1){1'b1}}};
            else
                line_err_next = err_reg[OEW-1:0];
            if (sum_ext[SUW] != sum_ext[SUW-1])
                error_sum_next = sum_ext[SUW] ? {1'b1, {(SUW-1){1'b0}}}
                                              : {1'b0, {(SUW-1){1'b1}}};
            else
                error_sum_next = sum_ext[SUW-1:0];
            last_err_next  = err_reg;
        end
    end

    // Control, configuration and PID state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= lfpd_pkg::GAIN_P_RST;
            gain_i_reg    <= lfpd_pkg::GAIN_I_RST;
            gain_d_reg    <= lfpd_pkg::GAIN_D_RST;
            base_reg      <= lfpd_pkg::BASE_SPEED_RST;
            top_reg       <= lfpd_pkg::TOP_SPEED_RST;
            last_err_reg  <= '0;
            error_sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            gain_p_reg    <= gain_p_next;
            gain_i_reg    <= gain_i_next;
            gain_d_reg    <= gain_d_next;
            base_reg      <= base_next;
            top_reg       <= top_next;
            last_err_reg  <= last_err_next;
            error_sum_reg <= error_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        seen_reg      <= seen_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        err_reg       <= err_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        line_err_reg  <= line_err_next;
        line_seen_reg <= line_seen_next;
    end

    assign status.seen     = seen_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign left_speed  = left_reg;
    assign right_speed = right_reg;
    assign line_error  = line_err_reg;
    assign line_seen   = line_seen_reg;

endmodule
